[rtl/lfgd_pkg.sv]
// Package: shared constants, payload structs, state enum and controller/datapath links.
package lfgd_pkg;

  localparam int MaxPoints = 1024;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CountW    = AddrW + 1;

  localparam logic [1:0] REG_LEARNING_RATE  = 2'd0;
  localparam logic [1:0] REG_TOLERANCE      = 2'd1;
  localparam logic [1:0] REG_MAX_ITERATIONS = 2'd2;

  localparam logic [15:0] LearningRateReset  = 16'd6554;
  localparam logic [31:0] ToleranceReset     = 32'd4295;
  localparam logic [19:0] MaxIterationsReset = 20'd100000;

  typedef struct packed {
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic               last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic               converged;
    logic [19:0]        iterations_used;
    logic               samples_dropped;
  } fit_result_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_START, ST_READ, ST_MUL1, ST_RES, ST_MUL2, ST_ACC,
    ST_SCALE, ST_DIV, ST_UPD, ST_NORM, ST_DONE
  } lfgd_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_fit;   // zero slope/intercept/iterations
    logic clear_acc;   // zero accumulators
    logic mul1;        // slope * x
    logic resid;       // form residual
    logic mul2;        // x * r
    logic accum;       // add into accumulators
    logic div_start;   // begin gradient scaling
    logic update;      // step slope and intercept
    logic norm;        // compute norm test
  } lfgd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic below_tol;
  } lfgd_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

[rtl/lfgd_ram.sv]
// Generic single-port RAM with registered read.
module lfgd_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write or read one word
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[rtl/lfgd_div.sv]
// Restoring divider: sat32(trunc(2*acc/n)), one quotient bit per cycle.
module lfgd_div import lfgd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] acc,
  input  logic [CountW-1:0]  n,
  output logic               done,
  output logic signed [31:0] quot
);
  logic [64:0] q;
  logic [CountW:0] rem;
  logic [6:0] cnt;
  logic busy, neg;
  logic [CountW:0] trial;

  assign trial = {rem[CountW-1:0], q[64]};

  // shift one bit of the dividend per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
      end else if (busy) begin
        if (cnt == 7'd64) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= acc[63];
      q   <= acc[63] ? {(64'd0 - acc), 1'b0} : {acc, 1'b0};
      rem <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, n}) begin
        rem <= trial - {1'b0, n};
        q   <= {q[63:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[63:0], 1'b0};
      end
    end
  end

  // saturate the magnitude back to signed
  always_comb begin
    if (neg) quot = (q > 65'h80000000) ? 32'sh80000000 : 32'(65'd0 - q);
    else     quot = (q > 65'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
  end
endmodule

[rtl/lfgd_datapath.sv]
// Datapath: sample store, residual and gradient arithmetic, update and norm test.
module lfgd_datapath import lfgd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lfgd_cmd_t          cmd,
  output lfgd_status_t       status,
  input  logic               wr_en,
  input  logic [AddrW-1:0]   addr,
  input  logic signed [31:0] wr_x,
  input  logic signed [31:0] wr_y,
  input  logic [CountW-1:0]  n,
  input  logic [15:0]        learning_rate,
  input  logic [31:0]        tolerance,
  output logic signed [31:0] slope,
  output logic signed [31:0] intercept
);
  logic signed [31:0] rx, ry, r;
  logic signed [63:0] prod1, prod2, acc_s, acc_i;
  logic signed [31:0] gs, gi, qs, qi;
  logic dn_s, dn_i, got_s, got_i;
  logic signed [63:0] s2, i2;
  logic [63:0] t2;
  logic signed [47:0] step_s, step_i;

  lfgd_ram #(.Width(32), .Depth(MaxPoints)) u_xram (
    .clk, .we(wr_en), .addr, .wdata(wr_x), .rdata(rx));
  lfgd_ram #(.Width(32), .Depth(MaxPoints)) u_yram (
    .clk, .we(wr_en), .addr, .wdata(wr_y), .rdata(ry));

  lfgd_div u_div_s (.clk, .rst, .start(cmd.div_start), .acc(acc_s), .n,
                    .done(dn_s), .quot(qs));
  lfgd_div u_div_i (.clk, .rst, .start(cmd.div_start), .acc(acc_i), .n,
                    .done(dn_i), .quot(qi));

  // residual pipeline and accumulation
  always_ff @(posedge clk) begin
    if (cmd.mul1) prod1 <= 64'(slope) * 64'(rx);
    if (cmd.resid) r <= sat32(66'(prod1 >>> 16) + 66'(intercept) - 66'(ry));
    if (cmd.mul2) prod2 <= 64'(rx) * 64'(r);
    if (cmd.clear_acc) begin
      acc_s <= '0;
      acc_i <= '0;
    end else if (cmd.accum) begin
      acc_s <= acc_s + (prod2 >>> 16);
      acc_i <= acc_i + 64'(r);
    end
  end

  // hold quotients until both dividers finish
  always_ff @(posedge clk) begin
    if (rst || cmd.div_start) begin
      got_s <= 1'b0;
      got_i <= 1'b0;
    end else begin
      if (dn_s) begin got_s <= 1'b1; gs <= qs; end
      if (dn_i) begin got_i <= 1'b1; gi <= qi; end
    end
  end
  assign status.div_done = got_s && got_i;

  assign step_s = 48'($signed({1'b0, learning_rate})) * 48'(gs);
  assign step_i = 48'($signed({1'b0, learning_rate})) * 48'(gi);

  // step parameters against the gradient
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_fit) begin
      slope     <= '0;
      intercept <= '0;
    end else if (cmd.update) begin
      slope     <= sat32(66'(slope) - 66'(step_s >>> 16));
      intercept <= sat32(66'(intercept) - 66'(step_i >>> 16));
    end
  end

  // squares registered, then compared
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      s2 <= 64'(gs) * 64'(gs);
      i2 <= 64'(gi) * 64'(gi);
      t2 <= 64'(tolerance) * 64'(tolerance);
    end
  end

  logic [63:0] g2;
  assign g2 = 64'(s2) + 64'(i2);
  assign status.below_tol = (g2[63:32] == 32'd0) && ({g2[31:0], 32'd0} < t2);
endmodule

[rtl/lfgd_ctrl.sv]
// Controller: load samples, sequence iterations over the store, issue result.
module lfgd_ctrl import lfgd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last_sample,
  output logic              busy,
  input  logic [19:0]       max_iterations,
  input  lfgd_status_t      status,
  output lfgd_cmd_t         cmd,
  output logic              wr_en,
  output logic [AddrW-1:0]  addr,
  output logic [CountW-1:0] n,
  output logic [19:0]       iter,
  output logic              conv,
  output logic              dropped,
  output logic              done
);
  lfgd_state_t state, state_next;
  logic [CountW-1:0] idx;
  logic accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_LOAD);
  assign wr_en  = accept && (n != CountW'(MaxPoints));
  assign addr   = (state == ST_LOAD) ? n[AddrW-1:0] : idx[AddrW-1:0];

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  // counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0; dropped <= 1'b0; iter <= '0; conv <= 1'b0; idx <= '0;
    end else begin
      if (accept) begin
        if (wr_en) n <= n + CountW'(1);
        else       dropped <= 1'b1;
      end
      if (cmd.clear_fit) begin iter <= '0; conv <= 1'b0; end
      if (cmd.clear_acc) idx <= '0;
      if (cmd.accum) idx <= idx + CountW'(1);
      if (cmd.update) iter <= iter + 20'd1;
      if (state == ST_NORM && status.below_tol) conv <= 1'b1;
      if (state == ST_DONE) begin n <= '0; dropped <= 1'b0; end
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd  = '0;
    done = 1'b0;
    case (state)
      ST_LOAD: if (accept && last_sample) begin
        state_next = ST_START;
      end
      ST_START: begin
        cmd.clear_fit = 1'b1;
        cmd.clear_acc = 1'b1;
        state_next = (n == '0 || max_iterations == 20'd0) ? ST_DONE : ST_READ;
      end
      ST_READ:  state_next = ST_MUL1;
      ST_MUL1: begin cmd.mul1 = 1'b1; state_next = ST_RES; end
      ST_RES:  begin cmd.resid = 1'b1; state_next = ST_MUL2; end
      ST_MUL2: begin cmd.mul2 = 1'b1; state_next = ST_ACC; end
      ST_ACC: begin
        cmd.accum = 1'b1;
        if (idx + CountW'(1) == n) state_next = ST_SCALE;
        else                       state_next = ST_READ;
      end
      // start scaling once the last point is in the accumulators
      ST_SCALE: begin
        cmd.div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: if (status.div_done) begin
        cmd.update = 1'b1;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        cmd.clear_acc = 1'b1;
        if (status.below_tol || iter == max_iterations) state_next = ST_DONE;
        else state_next = ST_READ;
      end
      ST_DONE: begin done = 1'b1; state_next = ST_LOAD; end
      default: state_next = ST_LOAD;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) done |=> state == ST_LOAD)
    else $error("done not followed by load");
  assert property (@(posedge clk) disable iff (rst) n <= CountW'(MaxPoints))
    else $error("point count overflow");
  assert property (@(posedge clk) disable iff (rst) cmd.update |=> iter != '0)
    else $error("update without iteration count");
endmodule

[rtl/line_fit_gradient_descent_core.sv]
// Top level: configuration registers, controller and datapath.
//
// Samples load one per cycle while busy is low; the item with last_sample set
// starts the fit. Each iteration steps every stored point through read, multiply,
// residual, multiply and accumulate, then starts the two 65-step gradient
// dividers, waits on them, and does the update and the norm check. The result
// appears for one cycle on result with done high; the receiver cannot stall
// it.
module line_fit_gradient_descent_core import lfgd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  sample_t     sample,
  output logic        done,
  output fit_result_t result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [15:0] learning_rate;
  logic [31:0] tolerance;
  logic [19:0] max_iterations;
  lfgd_cmd_t cmd;
  lfgd_status_t status;
  logic wr_en, conv, dropped;
  logic [AddrW-1:0] addr;
  logic [CountW-1:0] n;
  logic [19:0] iter;
  logic signed [31:0] slope, intercept;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate  <= LearningRateReset;
      tolerance      <= ToleranceReset;
      max_iterations <= MaxIterationsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARNING_RATE:  learning_rate  <= cfg_data[15:0];
        REG_TOLERANCE:      tolerance      <= cfg_data;
        REG_MAX_ITERATIONS: max_iterations <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  lfgd_ctrl u_ctrl (.clk, .rst, .start, .last_sample(sample.last_sample), .busy,
    .max_iterations, .status, .cmd, .wr_en, .addr, .n, .iter, .conv, .dropped,
    .done);

  lfgd_datapath u_dp (.clk, .rst, .cmd, .status, .wr_en, .addr,
    .wr_x(sample.sample_x), .wr_y(sample.sample_y), .n, .learning_rate,
    .tolerance, .slope, .intercept);

  assign result = '{slope: slope, intercept: intercept, converged: conv,
                    iterations_used: iter, samples_dropped: dropped};
endmodule

[bench/fit_checker.sv]
// Checker for the line fit core: tracks samples and settings, predicts fits, compares results.
module fit_checker import lfgd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  sample_t     sample,
  input  logic        done,
  input  fit_result_t result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] step_size;
  logic [31:0] tol;
  logic [19:0] iter_limit;

  int pt_x [MaxPoints];
  int pt_y [MaxPoints];
  int n_pts;
  bit dropped;

  fit_result_t fits_due[$];

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // 2*acc/n truncated toward zero, clamped to 32 bits
  function automatic int grad_scale(longint acc, int n);
    bit neg;
    longint unsigned mag;
    longint unsigned q;
    neg = acc < 0;
    mag = neg ? longint'(-acc) : acc;
    q = (mag * 2) / longint'(n);
    if (neg) return (q > 64'h8000_0000) ? 32'h80000000 : clamp32(-longint'(q));
    return (q > 64'h7FFF_FFFF) ? 32'h7FFFFFFF : int'(q);
  endfunction

  // squared gradient norm against squared tolerance, exact
  function automatic bit norm_below_tol(int gs, int gi);
    longint unsigned s2;
    longint unsigned i2;
    longint unsigned g2;
    longint unsigned t;
    s2 = longint'(gs) * longint'(gs);
    i2 = longint'(gi) * longint'(gi);
    g2 = s2 + i2;
    t = tol;
    if (g2 >= 64'h1_0000_0000) return 1'b0;
    return (g2 << 32) < (t * t);
  endfunction

  function automatic fit_result_t fit_line();
    fit_result_t res;
    int a;
    int b;
    int r;
    int gs;
    int gi;
    int unsigned it;
    bit conv;
    longint acc_s;
    longint acc_i;
    a = 0;
    b = 0;
    it = 0;
    conv = 1'b0;
    while (!conv && it < iter_limit) begin
      acc_s = 0;
      acc_i = 0;
      for (int i = 0; i < n_pts; i++) begin
        r = clamp32(((longint'(a) * longint'(pt_x[i])) >>> 16) + b - pt_y[i]);
        acc_s += (longint'(pt_x[i]) * longint'(r)) >>> 16;
        acc_i += r;
      end
      gs = grad_scale(acc_s, n_pts);
      gi = grad_scale(acc_i, n_pts);
      a = clamp32(longint'(a) - ((longint'(step_size) * longint'(gs)) >>> 16));
      b = clamp32(longint'(b) - ((longint'(step_size) * longint'(gi)) >>> 16));
      it++;
      conv = norm_below_tol(gs, gi);
    end
    res.slope = a;
    res.intercept = b;
    res.converged = conv;
    res.iterations_used = it[19:0];
    res.samples_dropped = dropped;
    return res;
  endfunction

  always @(posedge clk) begin
    fit_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      step_size = LearningRateReset;
      tol = ToleranceReset;
      iter_limit = MaxIterationsReset;
      n_pts = 0;
      dropped = 1'b0;
      fits_due.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      // settings writes
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARNING_RATE:  step_size = cfg_data[15:0];
          REG_TOLERANCE:      tol = cfg_data;
          REG_MAX_ITERATIONS: iter_limit = cfg_data[19:0];
          default: ;
        endcase
      end
      // compare a result beat with the oldest predicted fit
      if (done) begin
        if (fits_due.size() == 0) begin
          $error("unexpected result beat: slope %h intercept %h", result.slope,
                 result.intercept);
          errs++;
        end else begin
          want = fits_due.pop_front();
          if (result.slope !== want.slope) begin
            $error("slope: expected %h, actual %h", want.slope, result.slope);
            errs++;
          end
          if (result.intercept !== want.intercept) begin
            $error("intercept: expected %h, actual %h", want.intercept, result.intercept);
            errs++;
          end
          if (result.converged !== want.converged) begin
            $error("converged: expected %b, actual %b", want.converged, result.converged);
            errs++;
          end
          if (result.iterations_used !== want.iterations_used) begin
            $error("iterations_used: expected %0d, actual %0d", want.iterations_used,
                   result.iterations_used);
            errs++;
          end
          if (result.samples_dropped !== want.samples_dropped) begin
            $error("samples_dropped: expected %b, actual %b", want.samples_dropped,
                   result.samples_dropped);
            errs++;
          end
        end
      end
      // store an accepted sample beat, fit on the last one
      if (start && !busy) begin
        if (n_pts < MaxPoints) begin
          pt_x[n_pts] = sample.sample_x;
          pt_y[n_pts] = sample.sample_y;
          n_pts++;
        end else begin
          dropped = 1'b1;
        end
        if (sample.last_sample) begin
          fits_due.insert(fits_due.size(), fit_line());
          n_pts = 0;
          dropped = 1'b0;
        end
      end
      fail_count <= fail_count + errs;
      pending <= fits_due.size();
    end
  end

endmodule

[bench/tb_top.sv]
// Testbench top: drives sample sets and settings into the line fit core and reports the verdict.
module tb_top import lfgd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 20_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  sample_t     sample = '0;
  logic        done;
  fit_result_t result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_LEARNING_RATE;
  logic [31:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  int burst_left = 4;
  int rand_items = 0;

  line_fit_gradient_descent_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  fit_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // present one sample beat, hold until taken, then maybe idle
  task automatic send_point(int x, int y, bit last);
    start <= 1'b1;
    sample <= '{sample_x: x, sample_y: y, last_sample: last};
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // wait until every fit has reported and the core settles
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (16) @(posedge clk);
  endtask

  // write all three settings back to back
  task automatic configure(logic [15:0] lr, logic [31:0] tol, logic [19:0] iters);
    cfg_we <= 1'b1;
    cfg_index <= REG_LEARNING_RATE;
    cfg_data <= {16'b0, lr};
    @(posedge clk);
    cfg_index <= REG_TOLERANCE;
    cfg_data <= tol;
    @(posedge clk);
    cfg_index <= REG_MAX_ITERATIONS;
    cfg_data <= {12'b0, iters};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one data set: noisy line, full-range noise, or all zero
  task automatic send_set(int n, int kind);
    int a;
    int b;
    int x;
    int y;
    a = int'($urandom_range(0, 524288)) - 262144;
    b = int'($urandom_range(0, 655360)) - 327680;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: begin
          x = int'($urandom_range(0, 524288)) - 262144;
          y = int'((longint'(a) * x) >>> 16) + b + int'($urandom_range(0, 8192)) - 4096;
        end
        1: begin
          x = $urandom;
          y = $urandom;
        end
        default: begin
          x = 0;
          y = 0;
        end
      endcase
      send_point(x, y, i == n - 1);
    end
  endtask

  initial begin
    logic [15:0] lr;
    logic [31:0] tol;
    logic [19:0] iters;
    int pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, a single zero point converges at once
    send_point(0, 0, 1'b1);
    drain();

    // field extremes with saturation, never converging
    configure(16'hFFFF, 32'h0, 20'd3);
    send_point(32'h7FFFFFFF, 32'h80000000, 1'b0);
    send_point(32'h80000000, 32'h7FFFFFFF, 1'b0);
    send_point(32'hFFFFFFFF, 32'h00000001, 1'b0);
    send_point(32'h00010000, 32'h00010000, 1'b1);
    drain();

    // zero iteration limit
    configure(16'd6554, 32'd4295, 20'd0);
    send_point(123, 456, 1'b1);
    drain();

    // zero step size, huge tolerance
    configure(16'h0, 32'hFFFFFFFF, 20'd1);
    send_point(32'h00010000, 32'h00020000, 1'b1);
    drain();

    // largest iteration limit on data that converges immediately
    configure(16'd6554, 32'hFFFFFFFF, 20'hFFFFF);
    send_set(3, 2);
    drain();

    // store full: one point past capacity is dropped
    configure(16'd6554, 32'd4295, 20'd2);
    send_set(MaxPoints + 1, 0);
    drain();

    // random phases of settings and data sets; the cases above sent MaxPoints + 11
    while (rand_items < 1200 - (MaxPoints + 11)) begin
      pick = $urandom_range(0, 5);
      lr = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0 : 16'($urandom);
      pick = $urandom_range(0, 4);
      tol = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFFFFFF :
            (pick == 2) ? 32'($urandom) : 32'($urandom_range(0, 1 << 20));
      iters = ($urandom_range(0, 4) == 0) ? 20'd1 : 20'($urandom_range(1, 12));
      configure(lr, tol, iters);
      for (int s = 0; s < 20; s++) begin
        int n;
        int kind;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        pick = $urandom_range(0, 9);
        kind = (pick < 7) ? 0 : (pick < 9) ? 1 : 2;
        send_set(n, kind);
        rand_items += n;
      end
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
